FILE: sv/sorted_union_merge_core_defines.svh
// Assertion macros for the sorted union merge core.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef SORTED_UNION_MERGE_CORE_DEFINES_SVH
`define SORTED_UNION_MERGE_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SUM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted union merge: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SUM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted union merge: next-cycle check failed");

`else

`define SUM_ASSERT_IMPLY(label, ante, cons)
`define SUM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/sum_pkg.sv
// Shared constants and the command type of the sorted union merge core.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
`timescale 1ns / 1ps

package sum_pkg;

    localparam int CNT_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    // Request actions.
    localparam logic [1:0] ACT_FIRST  = 2'd0;
    localparam logic [1:0] ACT_SECOND = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_FIRST_BAD  = 3'd1;
    localparam logic [STAT_W-1:0] ST_SECOND_BAD = 3'd2;
    localparam logic [STAT_W-1:0] ST_BOTH_BAD   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;

    // Command kinds passed from the front end to the back end.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_RUN    = 1'b1;

    // List select inside an append command.
    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    // For an append, cnt_a is the write address. For a run, cnt_a and cnt_b
    // are the lengths of the first and second list.
    typedef struct packed {
        logic                     kind;
        logic                     sel;
        logic [CNT_W-1:0]         cnt_a;
        logic [CNT_W-1:0]         cnt_b;
        logic signed [VAL_W-1:0]  value;
        logic [STAT_W-1:0]        status;
        logic                     ovf;
    } sum_cmd_t;

endpackage

FILE: sv/sum_item_if.sv
// Request channel of the sorted union merge core: valid, ready and payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface sum_item_if;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);

endinterface

FILE: sv/sum_result_if.sv
// Result channel of the sorted union merge core: valid, ready and payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface sum_result_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] value_res;
    logic [2:0]         status;
    logic               overflowed;
    logic               last;

    modport source (output valid, output value_res, output status, output overflowed,
                    output last, input ready);
    modport sink (input valid, input value_res, input status, input overflowed,
                  input last, output ready);

endinterface

FILE: sv/sorted_union_merge_core.sv
// Top level of the sorted union merge core; uses sum_pkg, both interfaces and the defines header.
// Timing: a merged run passes the queue, then the back end's read and compare states, before
// its first result is registered; a status-only run goes from the queue straight to the output
// register. Commands queued ahead of a run delay it. One request per cycle is taken until the
// four-entry queue fills behind a merge; a merge returns to the read state before each compare.
// Reset (rst_n, async, active low) empties both lists, clears the overflow flag and the queue.
`timescale 1ns / 1ps
`include "sorted_union_merge_core_defines.svh"

module sorted_union_merge_core #(
    parameter int LIST_DEPTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    sum_item_if.sink     item,
    sum_result_if.source result
);

    import sum_pkg::*;

    // Commands travel from the front end to the back end through the queue.
    // An append carries its write address, so the front end can move on to the
    // next list fill while the back end is still merging the previous run; the
    // queue keeps the order, so those writes land only after the merge is done.
    sum_cmd_t q_push_cmd;
    sum_cmd_t q_pop_cmd;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    // High while a result other than ok is offered.
    logic     res_status_fail;

    assign res_status_fail = result.valid && (result.status != ST_OK);

    // The front end keeps the list lengths, a running sortedness flag per list
    // and the sticky overflow flag, so a run request already knows its status.
    sum_front #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .full  (q_full),
        .push  (q_push),
        .cmd   (q_push_cmd)
    );

    sum_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // The back end owns the list memories and the output register, which lets a
    // finished result wait for the consumer while the walk state holds.
    sum_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .cmd    (q_pop_cmd),
        .pop    (q_pop),
        .result (result)
    );

    // The front end never offers a command to a full queue.
    `SUM_ASSERT_IMPLY(a_no_push_when_full, q_push, !q_full)
    // A status result other than ok is always the only and last one, with zero value.
    `SUM_ASSERT_IMPLY(a_status_is_last, res_status_fail, result.last)
    `SUM_ASSERT_IMPLY(a_status_zero_value, res_status_fail, result.value_res == '0)
    // A command written into an empty queue is visible on the next cycle.
    `SUM_ASSERT_NEXT(a_queue_fills, q_push && q_empty, !q_empty)

endmodule

FILE: sv/sum_front.sv
// Front end: takes requests, tracks list lengths, sortedness and overflow,
// and turns each request into a command. Depends on sum_pkg and sum_item_if.
`timescale 1ns / 1ps

module sum_front #(
    parameter int LIST_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    sum_item_if.sink         item,
    input  logic             full,
    output logic             push,
    output sum_pkg::sum_cmd_t cmd
);

    import sum_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic [CNT_W-1:0]        first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0]        second_cnt_reg, second_cnt_next;
    logic                    first_ok_reg, first_ok_next;
    logic                    second_ok_reg, second_ok_next;
    logic                    ovf_reg, ovf_next;
    logic signed [VAL_W-1:0] first_tail_reg, first_tail_next;
    logic signed [VAL_W-1:0] second_tail_reg, second_tail_next;
    logic                    accept;
    logic [STAT_W-1:0]       run_status;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    // Sortedness is tracked on the fly, so a run needs no separate check pass.
    always_comb
    begin
        first_cnt_next   = first_cnt_reg;
        second_cnt_next  = second_cnt_reg;
        first_ok_next    = first_ok_reg;
        second_ok_next   = second_ok_reg;
        ovf_next         = ovf_reg;
        first_tail_next  = first_tail_reg;
        second_tail_next = second_tail_reg;
        push             = 1'b0;
        cmd              = '0;
        run_status       = ST_OK;
        if (!first_ok_reg && !second_ok_reg)
        begin
            run_status = ST_BOTH_BAD;
        end
        else if (!first_ok_reg)
        begin
            run_status = ST_FIRST_BAD;
        end
        else if (!second_ok_reg)
        begin
            run_status = ST_SECOND_BAD;
        end
        else if (first_cnt_reg == '0 && second_cnt_reg == '0)
        begin
            run_status = ST_EMPTY;
        end
        if (accept)
        begin
            case (item.action)
                ACT_FIRST:
                begin
                    if (first_cnt_reg < DEPTH_C)
                    begin
                        push           = 1'b1;
                        cmd.kind       = CMD_APPEND;
                        cmd.sel        = SEL_FIRST;
                        cmd.cnt_a      = first_cnt_reg;
                        cmd.value      = item.value;
                        first_cnt_next = first_cnt_reg + 1'b1;
                        if (first_cnt_reg != '0 && !(first_tail_reg < item.value))
                        begin
                            first_ok_next = 1'b0;
                        end
                        first_tail_next = item.value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_SECOND:
                begin
                    if (second_cnt_reg < DEPTH_C)
                    begin
                        push            = 1'b1;
                        cmd.kind        = CMD_APPEND;
                        cmd.sel         = SEL_SECOND;
                        cmd.cnt_a       = second_cnt_reg;
                        cmd.value       = item.value;
                        second_cnt_next = second_cnt_reg + 1'b1;
                        if (second_cnt_reg != '0 && !(second_tail_reg < item.value))
                        begin
                            second_ok_next = 1'b0;
                        end
                        second_tail_next = item.value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_RUN:
                begin
                    push            = 1'b1;
                    cmd.kind        = CMD_RUN;
                    cmd.cnt_a       = first_cnt_reg;
                    cmd.cnt_b       = second_cnt_reg;
                    cmd.status      = run_status;
                    cmd.ovf         = ovf_reg;
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    first_ok_next   = 1'b1;
                    second_ok_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            first_ok_reg   <= 1'b1;
            second_ok_reg  <= 1'b1;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            first_ok_reg   <= first_ok_next;
            second_ok_reg  <= second_ok_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_tail_reg  <= first_tail_next;
        second_tail_reg <= second_tail_next;
    end

endmodule

FILE: sv/sum_queue.sv
// Short command queue between the front end and the back end.
// Depends on sum_pkg.
`timescale 1ns / 1ps

module sum_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sum_pkg::sum_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output sum_pkg::sum_cmd_t pop_cmd,
    output logic              empty
);

    import sum_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    sum_cmd_t       entry_reg [QUEUE_DEPTH];
    logic [QAW:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   fill;

    assign fill    = wr_ptr_reg - rd_ptr_reg;
    assign full    = (fill == (QAW + 1)'(QUEUE_DEPTH));
    assign empty   = (fill == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg[QAW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg[QAW-1:0]] <= push_cmd;
        end
    end

endmodule

FILE: sv/sum_back.sv
// Back end: holds both lists in memories, executes appends and walks the
// lists for a merge from registered reads. Depends on sum_pkg, sum_result_if.
`timescale 1ns / 1ps

module sum_back #(
    parameter int LIST_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  sum_pkg::sum_cmd_t cmd,
    output logic              pop,
    sum_result_if.source      result
);

    import sum_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic signed [VAL_W-1:0] mem_a [LIST_DEPTH];
    logic signed [VAL_W-1:0] mem_b [LIST_DEPTH];
    logic signed [VAL_W-1:0] rd_a_reg, rd_b_reg;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        f_reg, f_next, g_reg, g_next;
    logic [CNT_W-1:0]        nf_reg, nf_next, ns_reg, ns_next;
    logic                    run_ovf_reg, run_ovf_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic                    out_ovf_reg, out_ovf_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    wr_a, wr_b;
    logic                    has_a, has_b;

    assign out_free          = !out_valid_reg || result.ready;
    assign has_a             = f_reg < nf_reg;
    assign has_b             = g_reg < ns_reg;
    assign result.valid      = out_valid_reg;
    assign result.value_res  = out_value_reg;
    assign result.status     = out_status_reg;
    assign result.overflowed = out_ovf_reg;
    assign result.last       = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        f_next          = f_reg;
        g_next          = g_reg;
        nf_next         = nf_reg;
        ns_next         = ns_reg;
        run_ovf_next    = run_ovf_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    if (cmd.kind == CMD_APPEND)
                    begin
                        pop  = 1'b1;
                        wr_a = (cmd.sel == SEL_FIRST);
                        wr_b = (cmd.sel == SEL_SECOND);
                    end
                    else if (cmd.status != ST_OK)
                    begin
                        // Failed check or two empty lists: a single status result.
                        if (out_free)
                        begin
                            pop             = 1'b1;
                            out_valid_next  = 1'b1;
                            out_value_next  = '0;
                            out_status_next = cmd.status;
                            out_ovf_next    = cmd.ovf;
                            out_last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        pop          = 1'b1;
                        f_next       = '0;
                        g_next       = '0;
                        nf_next      = cmd.cnt_a;
                        ns_next      = cmd.cnt_b;
                        run_ovf_next = cmd.ovf;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_ovf_next    = run_ovf_reg;
                    if (has_a && has_b)
                    begin
                        if (rd_a_reg < rd_b_reg)
                        begin
                            out_value_next = rd_a_reg;
                            f_next         = f_reg + 1'b1;
                        end
                        else if (rd_a_reg == rd_b_reg)
                        begin
                            // Equal heads appear once in the union.
                            out_value_next = rd_a_reg;
                            f_next         = f_reg + 1'b1;
                            g_next         = g_reg + 1'b1;
                        end
                        else
                        begin
                            out_value_next = rd_b_reg;
                            g_next         = g_reg + 1'b1;
                        end
                    end
                    else if (has_b)
                    begin
                        out_value_next = rd_b_reg;
                        g_next         = g_reg + 1'b1;
                    end
                    else
                    begin
                        out_value_next = rd_a_reg;
                        f_next         = f_reg + 1'b1;
                    end
                    out_last_next = (f_next >= nf_reg) && (g_next >= ns_reg);
                    state_next    = out_last_next ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg          <= f_next;
        g_reg          <= g_next;
        nf_reg         <= nf_next;
        ns_reg         <= ns_next;
        run_ovf_reg    <= run_ovf_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cmd.cnt_a[AW-1:0]] <= cmd.value;
        end
        if (wr_b)
        begin
            mem_b[cmd.cnt_a[AW-1:0]] <= cmd.value;
        end
        rd_a_reg <= mem_a[f_reg[AW-1:0]];
        rd_b_reg <= mem_b[g_reg[AW-1:0]];
    end

endmodule

FILE: verif/sorted_union_merge_core_tb.sv
// Testbench for sorted_union_merge_core: directed and random request streams, each
// result checked in order against a predictor of the two-list sorted union.
// Depends on sum_pkg, sum_item_if, sum_result_if and the core itself.
`timescale 1ns / 1ps

module sorted_union_merge_core_tb;

    import sum_pkg::*;

    localparam int LIST_DEPTH   = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    // The request action field is two bits wide, but only three codes are used.
    // The block must swallow the fourth without any effect.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // The full span of a 32-bit value, used to keep generated lists in range.
    localparam longint VALUE_SPAN = 64'sd4294967296;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_res;
        logic [STAT_W-1:0]       status;
        logic                    overflowed;
        logic                    last;
    } merge_result_t;

    typedef logic signed [VAL_W-1:0] list_store_t [LIST_DEPTH];

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sum_item_if   item_ch ();
    sum_result_if res_ch ();

    sorted_union_merge_core #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: the testbench's own copy of both lists, their fill levels
    // and the sticky overflow flag. Only reset clears the flag, and reset is
    // applied once, so every run after the first dropped append reports it.
    list_store_t   first_store;
    list_store_t   second_store;
    int unsigned   first_fill;
    int unsigned   second_fill;
    logic          overflow_seen;

    // Results that accepted run requests have promised, oldest first.
    merge_result_t union_expect_q [$];

    // Lists prepared by the generator, waiting to be sent as append requests.
    logic signed [VAL_W-1:0] pending_first [$];
    logic signed [VAL_W-1:0] pending_second [$];

    // Idle and stall odds, in percent per cycle, for the request and result sides.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned requests_sent;
    int unsigned runs_sent;
    int unsigned ignored_sent;
    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned cycle_count;

    // A list passes when every entry is strictly greater than the one before it.
    // An empty or single-entry list always passes.
    function automatic bit strictly_rising(input list_store_t entries,
                                           input int unsigned fill);
        bit          rising;
        int unsigned k;
        rising = 1'b1;
        for (k = 1; k < fill; k++)
        begin
            if (entries[k-1] >= entries[k])
                rising = 1'b0;
        end
        return rising;
    endfunction

    // Applies one accepted request to the predictor state. Appends only update
    // the lists and the overflow flag; a run queues the results the block owes and empties both lists.
    task automatic predict_union(input logic [1:0] action,
                                 input logic signed [VAL_W-1:0] value);
        merge_result_t     outcome;
        logic [STAT_W-1:0] verdict;
        int unsigned       fi;
        int unsigned       si;
        fi = 0;
        si = 0;
        outcome = '0;
        case (action)
            ACT_FIRST:
            begin
                if (first_fill < LIST_DEPTH)
                begin
                    first_store[first_fill] = value;
                    first_fill++;
                end
                else
                    overflow_seen = 1'b1;
            end
            ACT_SECOND:
            begin
                if (second_fill < LIST_DEPTH)
                begin
                    second_store[second_fill] = value;
                    second_fill++;
                end
                else
                    overflow_seen = 1'b1;
            end
            ACT_RUN:
            begin
                // The two failure codes are separate bits, so both failing
                // lists together give the combined code.
                verdict = ST_OK;
                if (!strictly_rising(first_store, first_fill))
                    verdict = verdict | ST_FIRST_BAD;
                if (!strictly_rising(second_store, second_fill))
                    verdict = verdict | ST_SECOND_BAD;
                outcome.overflowed = overflow_seen;
                if (verdict != ST_OK)
                begin
                    outcome.status = verdict;
                    outcome.last   = 1'b1;
                    union_expect_q.push_back(outcome);
                end
                else if (first_fill == 0 && second_fill == 0)
                begin
                    outcome.status = ST_EMPTY;
                    outcome.last   = 1'b1;
                    union_expect_q.push_back(outcome);
                end
                else
                begin
                    // Two-pointer walk; a value found in both lists advances
                    // both pointers and is emitted once.
                    outcome.status = ST_OK;
                    while (fi < first_fill || si < second_fill)
                    begin
                        if (fi < first_fill && si < second_fill)
                        begin
                            if (first_store[fi] < second_store[si])
                            begin
                                outcome.value_res = first_store[fi];
                                fi++;
                            end
                            else if (first_store[fi] == second_store[si])
                            begin
                                outcome.value_res = first_store[fi];
                                fi++;
                                si++;
                            end
                            else
                            begin
                                outcome.value_res = second_store[si];
                                si++;
                            end
                        end
                        else if (si < second_fill)
                        begin
                            outcome.value_res = second_store[si];
                            si++;
                        end
                        else
                        begin
                            outcome.value_res = first_store[fi];
                            fi++;
                        end
                        outcome.last = (fi >= first_fill && si >= second_fill);
                        union_expect_q.push_back(outcome);
                    end
                end
                first_fill  = 0;
                second_fill = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Presents one request at the falling edge and holds it until the block takes
    // it at a rising edge. Valid is left high afterwards, so back-to-back requests
    // never lower and raise it within one time step; a gap lowers it first.
    task automatic send_request(input logic [1:0] action,
                                input logic signed [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= action;
        item_ch.value  <= value;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        predict_union(action, value);
        if (action == ACT_UNUSED)
            ignored_sent++;
        else
            requests_sent++;
        if (action == ACT_RUN)
            runs_sent++;
        @(negedge clk);
    endtask

    // Builds two strictly increasing lists from one shared pool of values, so that
    // values common to both lists come up often where allowed. The pool starts at
    // the most negative value, near zero, at a random point, or runs down from the
    // most positive value; step sizes range from tiny to very wide.
    task automatic make_lists(input int unsigned n_a, input int unsigned n_b,
                              input bit allow_shared);
        longint                  step_max;
        longint                  span;
        longint                  cur;
        bit                      descending;
        bit                      started;
        int unsigned             need_a;
        int unsigned             need_b;
        int unsigned             pick;
        logic signed [VAL_W-1:0] v;
        pending_first.delete();
        pending_second.delete();
        case ($urandom_range(0, 2))
            0:       step_max = 3;
            1:       step_max = 64'sd1 << 20;
            default: step_max = 64'sd1 << 28;
        endcase
        if (step_max > (VALUE_SPAN - 1) / (n_a + n_b + 1))
            step_max = (VALUE_SPAN - 1) / (n_a + n_b + 1);
        span = step_max * (n_a + n_b);
        descending = 1'b0;
        case ($urandom_range(0, 3))
            0: cur = longint'(VAL_MIN);
            1:
            begin
                cur = longint'(VAL_MAX);
                descending = 1'b1;
            end
            2: cur = -(span / 2);
            default: cur = longint'(VAL_MIN) + longint'($urandom) % (VALUE_SPAN - span);
        endcase
        need_a  = n_a;
        need_b  = n_b;
        started = 1'b0;
        while (need_a + need_b > 0)
        begin
            if (started)
            begin
                if (descending)
                    cur = cur - 1 - longint'($urandom) % step_max;
                else
                    cur = cur + 1 + longint'($urandom) % step_max;
            end
            started = 1'b1;
            v = cur[VAL_W-1:0];
            // 0 puts the value in the first list, 1 in the second, 2 in both.
            if (need_a > 0 && need_b > 0)
                pick = $urandom_range(0, allow_shared ? 2 : 1);
            else
                pick = (need_a > 0) ? 0 : 1;
            if (pick != 1)
            begin
                need_a--;
                if (descending)
                    pending_first.push_front(v);
                else
                    pending_first.push_back(v);
            end
            if (pick != 0)
            begin
                need_b--;
                if (descending)
                    pending_second.push_front(v);
                else
                    pending_second.push_back(v);
            end
        end
    endtask

    // Breaks the order of a prepared list, either by repeating an entry (equal
    // neighbors fail the strict check) or by swapping two neighbors.
    task automatic spoil_order(ref logic signed [VAL_W-1:0] entries [$]);
        int unsigned             k;
        logic signed [VAL_W-1:0] held;
        if (entries.size() >= 2)
        begin
            k = $urandom_range(0, entries.size() - 2);
            if ($urandom_range(0, 1))
                entries[k+1] = entries[k];
            else
            begin
                held         = entries[k];
                entries[k]   = entries[k+1];
                entries[k+1] = held;
            end
        end
    endtask

    // Sends both prepared lists as appends, interleaved at random between the two
    // lists but in order within each, with the odd unused code mixed in as noise,
    // and closes the sequence with a run request carrying a random value field.
    task automatic send_lists(input int unsigned noise_pct);
        int unsigned ia;
        int unsigned ib;
        ia = 0;
        ib = 0;
        while (ia < pending_first.size() || ib < pending_second.size())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(ACT_UNUSED, $urandom);
            if (ib >= pending_second.size() ||
                (ia < pending_first.size() && $urandom_range(0, 1) == 1))
            begin
                send_request(ACT_FIRST, pending_first[ia]);
                ia++;
            end
            else
            begin
                send_request(ACT_SECOND, pending_second[ib]);
                ib++;
            end
        end
        send_request(ACT_RUN, $urandom);
    endtask

    // Mostly short lists, which keep runs frequent; now and then a long one, and
    // where allowed a list that runs past the capacity.
    function automatic int unsigned pick_size(input bit allow_overflow);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (allow_overflow && roll < 6)
            return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
        if (roll < 70)
            return $urandom_range(0, 5);
        if (roll < 94)
            return $urandom_range(6, 16);
        return $urandom_range(17, LIST_DEPTH);
    endfunction

    // A run with nothing loaded reports the empty status; its value field is
    // ignored whatever it holds.
    task automatic test_empty_run();
        send_request(ACT_RUN, '0);
        send_request(ACT_RUN, '1);
    endtask

    // The unused action code must leave the lists untouched: only the single
    // real append comes back.
    task automatic test_ignored_code();
        send_request(ACT_UNUSED, VAL_MIN);
        send_request(ACT_FIRST, 32'sd5);
        send_request(ACT_UNUSED, -32'sd1);
        send_request(ACT_RUN, VAL_MAX);
    endtask

    // Both extremes of the value range appear in both lists and must come out
    // once each, around a zero that only the second list holds.
    task automatic test_value_extremes();
        send_request(ACT_FIRST, VAL_MIN);
        send_request(ACT_FIRST, VAL_MAX);
        send_request(ACT_SECOND, VAL_MIN);
        send_request(ACT_SECOND, 32'sd0);
        send_request(ACT_SECOND, VAL_MAX);
        send_request(ACT_RUN, VAL_MIN);
    endtask

    // One list empty, the other not: the result is the loaded list unchanged.
    task automatic test_one_sided();
        send_request(ACT_FIRST, -32'sd1);
        send_request(ACT_FIRST, 32'sd7);
        send_request(ACT_RUN, '0);
        send_request(ACT_SECOND, 32'sd3);
        send_request(ACT_RUN, '0);
    endtask

    // Each failure status on its own, a repeated value counting as unsorted, and
    // a final empty run to show that a failed check still clears both lists.
    task automatic test_unsorted_lists();
        send_request(ACT_FIRST, 32'sd5);
        send_request(ACT_FIRST, 32'sd5);
        send_request(ACT_SECOND, 32'sd1);
        send_request(ACT_RUN, '0);
        send_request(ACT_SECOND, 32'sd2);
        send_request(ACT_SECOND, 32'sd1);
        send_request(ACT_RUN, '0);
        send_request(ACT_FIRST, 32'sd1);
        send_request(ACT_FIRST, 32'sd0);
        send_request(ACT_SECOND, 32'sd9);
        send_request(ACT_SECOND, 32'sd9);
        send_request(ACT_RUN, '0);
        send_request(ACT_RUN, '0);
    endtask

    // Random well-formed sequences with random content under one idling pattern,
    // with a share of unsorted lists and unused codes as broken input.
    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned item_goal,
                                     input bit allow_overflow);
        int unsigned start_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = requests_sent;
        while (requests_sent - start_count < item_goal)
        begin
            make_lists(pick_size(allow_overflow), pick_size(allow_overflow), 1'b1);
            if ($urandom_range(0, 99) < 12)
                spoil_order(pending_first);
            if ($urandom_range(0, 99) < 12)
                spoil_order(pending_second);
            send_lists(4);
        end
    endtask

    // Both lists filled to capacity with no shared values: the longest merge the
    // block can produce, one result per stored entry.
    task automatic test_full_capacity();
        make_lists(LIST_DEPTH, LIST_DEPTH, 1'b0);
        send_lists(0);
    endtask

    // Appends past capacity on each list in turn. The extra values are dropped,
    // the rest still merges, and the sticky flag shows on every later result.
    task automatic test_overflow();
        make_lists(LIST_DEPTH + 2, 3, 1'b1);
        send_lists(0);
        make_lists(2, LIST_DEPTH + 1, 1'b1);
        send_lists(0);
        send_request(ACT_RUN, '0);
    endtask

    // The result side stalls at random: each falling edge draws a new ready.
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Every result taken at a rising edge is matched against the oldest
    // expectation. A result with none waiting is a failure as well.
    always @(posedge clk)
    begin : result_check
        merge_result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (union_expect_q.size() == 0)
            begin
                $error("Result with none expected: value_res %0d status %0d last %0b",
                       res_ch.value_res, res_ch.status, res_ch.last);
                fail_count++;
            end
            else
            begin
                want = union_expect_q.pop_front();
                results_checked++;
                if (res_ch.value_res !== want.value_res)
                begin
                    $error("Field value_res: expected %0d, actual %0d",
                           want.value_res, res_ch.value_res);
                    fail_count++;
                end
                if (res_ch.status !== want.status)
                begin
                    $error("Field status: expected %0d, actual %0d",
                           want.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.overflowed !== want.overflowed)
                begin
                    $error("Field overflowed: expected %0b, actual %0b",
                           want.overflowed, res_ch.overflowed);
                    fail_count++;
                end
                if (res_ch.last !== want.last)
                begin
                    $error("Field last: expected %0b, actual %0b",
                           want.last, res_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: the limit is many times the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results still expected.",
                     cycle_count, union_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_FIRST;
        item_ch.value   = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        first_fill      = 0;
        second_fill     = 0;
        overflow_seen   = 1'b0;
        requests_sent   = 0;
        runs_sent       = 0;
        ignored_sent    = 0;
        results_checked = 0;
        fail_count      = 0;
        cycle_count     = 0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed cases run back to back, without idling on either side.
        test_empty_run();
        test_ignored_code();
        test_value_extremes();
        test_one_sided();
        test_unsorted_lists();

        // Random phases before any overflow, so the flag reads clear here.
        test_random_phase(0, 0, 40, 1'b0);
        test_random_phase(73, 0, 40, 1'b0);
        test_random_phase(0, 73, 40, 1'b0);

        test_full_capacity();
        test_overflow();

        // Once the flag has been set it stays set, so overflowing lists are
        // allowed in this last phase.
        test_random_phase(27, 27, 50, 1'b1);

        item_ch.valid <= 1'b0;
        while (union_expect_q.size() != 0)
            @(posedge clk);
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, %0d of them runs, plus %0d unused action codes.",
                 requests_sent, runs_sent, ignored_sent);
        $display("Checked %0d results over four idling patterns, full lists and overflow.",
                 results_checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/sum_pkg.sv
sv/sum_item_if.sv
sv/sum_result_if.sv
sv/sum_front.sv
sv/sum_queue.sv
sv/sum_back.sv
sv/sorted_union_merge_core.sv
verif/sorted_union_merge_core_tb.sv
